>>> hw/rtl/pal_pkg.sv
package pal_pkg;

   localparam int DEPTH  = 128;
   localparam int DATA_W = 32;
   localparam int CNT_W  = 8;
   localparam int POS_W  = 8;

   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(100);
   localparam logic [CNT_W-1:0] DEPTH_CNT   = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      CMD_INSERT    = 2'd0,
      CMD_REMOVE    = 2'd1,
      CMD_OVERWRITE = 2'd2,
      CMD_READ      = 2'd3
   } cmd_type;

   typedef struct packed {
      logic             ins;
      logic             rem;
      logic             wr;
      logic [CNT_W-1:0] tgt;
   } op_type;

   typedef struct packed {
      logic             status;
      logic             rd_en;
      logic [CNT_W-1:0] count;
      logic             empty;
      logic             full;
   } res_type;

endpackage

>>> hw/rtl/positional_array_list.sv
// Responses are registered. Throughput: one command per cycle while the
// response is not stalled; every cell of the chain shifts, writes or
// holds its entry in the same cycle, and the read value is registered.
// Reset (synchronous, active high) clears the entry count and the response
// valid and sets the list limit to 100; entry contents are left as they are.
module positional_array_list
   import pal_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic        [1:0]        req_command,
   input  logic        [POS_W-1:0]  req_position,
   input  logic signed [DATA_W-1:0] req_write_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_status,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic        [CNT_W-1:0]  rsp_entry_count,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full,
   input  logic                     csr_write_enable,
   input  logic        [CNT_W-1:0]  csr_write_data
);

   logic                     accept;
   op_type                   op;
   res_type                  res;
   logic signed [DATA_W-1:0] cell_data [DEPTH];
   logic signed [DATA_W-1:0] rd_sel;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     status_ff;
   logic signed [DATA_W-1:0] read_value_ff;
   logic        [CNT_W-1:0]  count_ff;
   logic                     empty_ff;
   logic                     full_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   pal_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .command          (req_command),
      .position         (req_position),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .op               (op),
      .res              (res)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_data;
      logic signed [DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = req_write_value;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      pal_cell u_cell (
         .clock       (clock),
         .op          (op),
         .cell_index  (CNT_W'(i)),
         .write_value (req_write_value),
         .left_data   (left_data),
         .right_data  (right_data),
         .data        (cell_data[i])
      );
   end

   always_comb begin
      rd_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (op.tgt == CNT_W'(i)) begin
            rd_sel = cell_data[i];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= res.status;
         read_value_ff <= res.rd_en ? rd_sel : '0;
         count_ff      <= res.count;
         empty_ff      <= res.empty;
         full_ff       <= res.full;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;

endmodule

>>> hw/rtl/pal_cell.sv
module pal_cell
   import pal_pkg::*;
(
   input  logic                     clock,
   input  op_type                   op,
   input  logic        [CNT_W-1:0]  cell_index,
   input  logic signed [DATA_W-1:0] write_value,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   output logic signed [DATA_W-1:0] data
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic                     at_tgt;
   logic                     above_tgt;

   assign at_tgt    = (cell_index == op.tgt);
   assign above_tgt = (cell_index > op.tgt);

   always_comb begin
      data_in = data_ff;
      if (op.ins) begin
         if (at_tgt) begin
            data_in = write_value;
         end else if (above_tgt) begin
            data_in = left_data;
         end
      end else if (op.rem) begin
         if (at_tgt || above_tgt) begin
            data_in = right_data;
         end
      end else if (op.wr) begin
         if (at_tgt) begin
            data_in = write_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> hw/rtl/pal_ctrl.sv
module pal_ctrl
   import pal_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [1:0]       command,
   input  logic [POS_W-1:0] position,
   input  logic             csr_write_enable,
   input  logic [CNT_W-1:0] csr_write_data,
   output op_type           op,
   output res_type          res
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] limit_ff;
   logic [CNT_W-1:0] limit_in;
   logic [CNT_W-1:0] eff_limit;
   logic             has_room;
   logic             ins_pos_ok;
   logic             in_range;
   logic             ok;
   cmd_type          cmd;

   assign cmd        = cmd_type'(command);
   assign eff_limit  = (limit_ff > DEPTH_CNT) ? DEPTH_CNT : limit_ff;
   assign has_room   = (count_ff < eff_limit);
   assign ins_pos_ok = (position != '0) &&
                       ({1'b0, position} <= ({1'b0, count_ff} + (CNT_W+1)'(1)));
   assign in_range   = (position != '0) && (position <= count_ff);

   always_comb begin
      case (cmd)
         CMD_INSERT: ok = has_room && ins_pos_ok;
         default:    ok = in_range;
      endcase
   end

   always_comb begin
      op.ins = accept && ok && (cmd == CMD_INSERT);
      op.rem = accept && ok && (cmd == CMD_REMOVE);
      op.wr  = accept && ok && (cmd == CMD_OVERWRITE);
      op.tgt = position - CNT_W'(1);
   end

   always_comb begin
      count_in = count_ff;
      if (op.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (op.rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign limit_in = csr_write_enable ? csr_write_data : limit_ff;

   always_comb begin
      res.status = !ok;
      res.rd_en  = ok && (cmd == CMD_READ);
      res.count  = count_in;
      res.empty  = (count_in == '0);
      res.full   = (count_in >= eff_limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         count_ff <= count_in;
         limit_ff <= limit_in;
      end
   end

endmodule
